// ----- design/brstamp_pkg.sv -----
`timescale 1ns / 1ps
package brstamp_pkg;
	localparam int CoordW  = 24;
	localparam int RadW    = 16;
	localparam int AlphaW  = 9;
	localparam int SizeW   = 13;
	localparam int SmoothW = 9;
	localparam int RatioW  = 10;
	localparam int CarryW  = 23;
	localparam int LenW    = 25;
	localparam int SqW     = 50;
	localparam int TW      = 27;
	localparam int ProdW   = 52;
	localparam int NumW    = 53;
	localparam int QW      = 27;
	localparam int DataW   = 80;

	localparam logic [1:0] CMD_PRESS   = 2'd0;
	localparam logic [1:0] CMD_MOVE    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [1:0] REG_SIZE   = 2'd0;
	localparam logic [1:0] REG_SMOOTH = 2'd1;
	localparam logic [1:0] REG_RATIO  = 2'd2;
endpackage

// ----- design/brush_stroke_stamp_spacer.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake         payload
// s_*       in   s_tvalid/s_tready pen event: tuser cmd, tdata pen point, radius, alpha
// m_*       out  m_tvalid/m_tready stamp: tdata position, radius, alpha; tlast last stamp
// apb       in   psel/penable      brush_size, smoothing_factor, spacing_ratio
// a move runs pull and squares, a 25-step root, a 27-step carry mod, then store
// and check; a zero-length move ends after the root
// each stamp then takes two 27-step passes of the one shared divider
// a press goes straight to the output handshake; release and ignored events keep it idle
// s_tready is high only while idle; a stalled stamp holds the block in place
// arst_n clears the stroke, head, carry and registers to their reset values
module brush_stroke_stamp_spacer
	import brstamp_pkg::*;
#(
	parameter int MAX_STAMPS_PER_EVENT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DataW-1:0]  s_tdata,  // pen_x, pen_y, stamp_radius, stamp_alpha, zero pad
	input  logic [1:0]        s_tuser,  // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DataW-1:0]  m_tdata,  // stamp_x, stamp_y, out_radius, out_alpha, zero pad
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int NCW = $clog2(MAX_STAMPS_PER_EVENT + 1);
	localparam logic [NCW-1:0] MaxN = NCW'(MAX_STAMPS_PER_EVENT);

	localparam logic [3:0] S_IDLE = 4'd0, S_PX = 4'd1, S_PY = 4'd2, S_DX = 4'd3,
		S_SQX = 4'd4, S_SQY = 4'd5, S_SQRT = 4'd6, S_DIV = 4'd7, S_CAR = 4'd8,
		S_CHK = 4'd9, S_MX = 4'd10, S_NX = 4'd11, S_FX = 4'd12, S_NY = 4'd13,
		S_FY = 4'd14, S_OUT = 4'd15;

	logic [3:0]          state_q, dret_q;
	logic [SizeW-1:0]    size_q;
	logic [SmoothW-1:0]  smooth_q;
	logic [RatioW-1:0]   ratio_q;
	logic                active_q;
	logic signed [CoordW-1:0] head_x_q, head_y_q, old_x_q, old_y_q, pen_x_q, pen_y_q;
	logic [CarryW-1:0]   carry_q;
	logic [RadW-1:0]     rad_q;
	logic [AlphaW-1:0]   alpha_q;
	logic signed [ProdW-1:0] prod_q;
	logic [SqW-1:0]      acc_q, sv_q, sr_q, sb_q;
	logic [4:0]          cnt_q;
	logic [LenW-1:0]     len_q, den_q;
	logic [25:0]         rem_q;
	logic [QW-1:0]       qsh_q;
	logic                neg_q;
	logic signed [TW-1:0] t_q;
	logic [NCW-1:0]      n_q;
	logic signed [CoordW-1:0] sx_q, sy_q;
	logic                last_q, ovalid_q;

	// apb
	logic wr;
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_comb begin
		case (paddr[3:2])
			REG_SIZE:   prdata = 32'(size_q);
			REG_SMOOTH: prdata = 32'(smooth_q);
			REG_RATIO:  prdata = 32'(ratio_q);
			default:    prdata = '0;
		endcase
	end

	// shared datapath
	logic [SmoothW-1:0]       s_eff;
	logic [CarryW-1:0]        spacing;
	logic [CarryW-1:0]        raw_sp;
	logic signed [LenW-1:0]   dx, dy;
	logic signed [LenW-1:0]   mul_a;
	logic signed [TW-1:0]     mul_b;
	logic signed [ProdW-1:0]  rnd;
	logic [SqW-1:0]           sq_sum, sr_try, nres, nv;
	logic                     sq_ge;
	logic [25:0]              dsh;
	logic                     dge;
	logic [ProdW-1:0]         pabs;
	logic [NumW-1:0]          stamp_num;
	logic [NumW-1:0]          car_num;
	logic signed [28:0]       fsum;
	logic signed [CoordW-1:0] fsat;
	logic signed [TW-1:0]     t_next;
	logic                     more;

	assign s_eff  = (smooth_q > SmoothW'(256)) ? SmoothW'(256) : smooth_q;
	assign raw_sp = CarryW'(size_q * ratio_q);
	assign spacing = (raw_sp < CarryW'(256)) ? CarryW'(256) : raw_sp;
	assign dx = LenW'(head_x_q) - LenW'(old_x_q);
	assign dy = LenW'(head_y_q) - LenW'(old_y_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PX: begin
				mul_a = LenW'(pen_x_q) - LenW'(old_x_q);
				mul_b = TW'(s_eff);
			end
			S_PY: begin
				mul_a = LenW'(pen_y_q) - LenW'(old_y_q);
				mul_b = TW'(s_eff);
			end
			S_DX: begin
				mul_a = dx;
				mul_b = TW'(dx);
			end
			S_SQX: begin
				mul_a = dy;
				mul_b = TW'(dy);
			end
			S_MX: begin
				mul_a = dx;
				mul_b = t_q;
			end
			S_FX: begin
				mul_a = dy;
				mul_b = t_q;
			end
			default: ;
		endcase
	end

	// round half up for the head pull
	assign rnd = (prod_q + ProdW'(128)) >>> 8;

	assign sq_sum = acc_q + SqW'(prod_q);
	assign sr_try = sr_q + sb_q;
	assign sq_ge  = sv_q >= sr_try;
	assign nres   = sq_ge ? ((sr_q >> 1) + sb_q) : (sr_q >> 1);
	assign nv     = sq_ge ? (sv_q - sr_try) : sv_q;
	assign car_num = NumW'(carry_q) + NumW'(nres[LenW-1:0]);

	assign dsh = {rem_q[24:0], qsh_q[QW-1]};
	assign dge = dsh >= {1'b0, den_q};

	assign pabs = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
	assign stamp_num = NumW'(pabs) + NumW'(len_q >> 1);

	always_comb begin
		logic signed [28:0] qv;
		qv = {2'b00, qsh_q};
		fsum = 29'(state_q == S_FX ? old_x_q : old_y_q) + (neg_q ? -qv : qv);
		if (fsum > 29'sd8388607)
			fsat = CoordW'(24'sh7fffff);
		else if (fsum < -29'sd8388608)
			fsat = CoordW'(24'sh800000);
		else
			fsat = fsum[CoordW-1:0];
	end

	// stamp distance may be negative when the carry outgrew a shrunk spacing
	assign t_next = t_q + TW'(spacing);
	assign more = (t_next <= $signed(TW'(len_q))) && ((n_q + NCW'(1)) < MaxN);

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(mul_a * mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dret_q   <= S_IDLE;
			size_q   <= SizeW'(20);
			smooth_q <= SmoothW'(256);
			ratio_q  <= RatioW'(26);
			active_q <= 1'b0;
			head_x_q <= '0;
			head_y_q <= '0;
			carry_q  <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			n_q      <= '0;
		end else begin
			if (wr) begin
				case (paddr[3:2])
					REG_SIZE:   size_q   <= pwdata[SizeW-1:0];
					REG_SMOOTH: smooth_q <= pwdata[SmoothW-1:0];
					REG_RATIO:  ratio_q  <= pwdata[RatioW-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pen_x_q <= s_tdata[23:0];
						pen_y_q <= s_tdata[47:24];
						rad_q   <= s_tdata[63:48];
						alpha_q <= s_tdata[72:64];
						old_x_q <= head_x_q;
						old_y_q <= head_y_q;
						case (s_tuser)
							CMD_PRESS: begin
								if (!active_q) begin
									active_q <= 1'b1;
									head_x_q <= s_tdata[23:0];
									head_y_q <= s_tdata[47:24];
									sx_q     <= s_tdata[23:0];
									sy_q     <= s_tdata[47:24];
									carry_q  <= '0;
									n_q      <= '0;
									last_q   <= 1'b1;
									ovalid_q <= 1'b1;
									state_q  <= S_OUT;
								end
							end
							CMD_MOVE: if (active_q) state_q <= S_PX;
							CMD_RELEASE: active_q <= 1'b0;
							default: ;
						endcase
					end
				end
				S_PX: state_q <= S_PY;
				S_PY: begin
					head_x_q <= old_x_q + CoordW'(rnd);
					state_q  <= S_DX;
				end
				S_DX: begin
					head_y_q <= old_y_q + CoordW'(rnd);
					state_q  <= S_SQX;
				end
				S_SQX: begin
					acc_q   <= SqW'(prod_q);
					state_q <= S_SQY;
				end
				S_SQY: begin
					sv_q    <= sq_sum;
					sr_q    <= '0;
					sb_q    <= SqW'(1) << 48;
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					sv_q  <= nv;
					sr_q  <= nres;
					sb_q  <= sb_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd24) begin
						len_q <= nres[LenW-1:0];
						t_q   <= TW'(spacing) - TW'(carry_q);
						n_q   <= '0;
						if (nres[LenW-1:0] == '0) begin
							state_q <= S_IDLE;
						end else begin
							rem_q   <= car_num[NumW-1:QW];
							qsh_q   <= car_num[QW-1:0];
							den_q   <= LenW'(spacing);
							cnt_q   <= '0;
							dret_q  <= S_CAR;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= dge ? (dsh - {1'b0, den_q}) : dsh;
					qsh_q <= {qsh_q[QW-2:0], dge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QW - 1)) state_q <= dret_q;
				end
				S_CAR: begin
					carry_q <= rem_q[CarryW-1:0];
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (t_q <= $signed(TW'(len_q)) && n_q < MaxN)
						state_q <= S_MX;
					else
						state_q <= S_IDLE;
				end
				S_MX: state_q <= S_NX;
				S_NX, S_NY: begin
					neg_q   <= prod_q[ProdW-1];
					rem_q   <= stamp_num[NumW-1:QW];
					qsh_q   <= stamp_num[QW-1:0];
					den_q   <= len_q;
					cnt_q   <= '0;
					dret_q  <= (state_q == S_NX) ? S_FX : S_FY;
					state_q <= S_DIV;
				end
				S_FX: begin
					sx_q    <= fsat;
					state_q <= S_NY;
				end
				S_FY: begin
					sy_q     <= fsat;
					last_q   <= !more;
					ovalid_q <= 1'b1;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						ovalid_q <= 1'b0;
						t_q      <= t_next;
						n_q      <= n_q + NCW'(1);
						state_q  <= last_q ? S_IDLE : S_MX;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, alpha_q, rad_q, sy_q, sx_q};

	a_ready_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input ready while a stamp is pending");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < {1'b0, den_q}) else $error("divider remainder overflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MaxN) else $error("stamp count past cap");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready) else $error("no return to idle");
endmodule

// ----- tb/brush_stroke_stamp_spacer_tb.sv -----
`timescale 1ns / 1ps
module brush_stroke_stamp_spacer_tb;
	import brstamp_pkg::*;

	localparam int MaxStamps = 64;
	localparam longint CycleLimit = 3000000;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0]        radius;
		logic [8:0]         alpha;
		logic               last;
	} stamp_t;

	class stamp_scoreboard;
		// predictor state
		logic [12:0] brush_size;
		logic [8:0]  smoothing;
		logic [9:0]  ratio;
		bit          in_stroke;
		longint      head_x, head_y;
		longint      carry;
		stamp_t      pending[$];
		int          errors;

		function void init();
			brush_size = 13'd20;
			smoothing  = 9'd256;
			ratio      = 10'd26;
			in_stroke  = 0;
			head_x     = 0;
			head_y     = 0;
			carry      = 0;
			errors     = 0;
		endfunction

		function longint floor256(longint v);
			if (v >= 0)
				return v / 256;
			return -((-v + 255) / 256);
		endfunction

		function longint round_div(longint num, longint den);
			if (num >= 0)
				return (num + den / 2) / den;
			return -((-num + den / 2) / den);
		endfunction

		function longint sat(longint v);
			if (v > 8388607)
				return 8388607;
			if (v < -8388608)
				return -8388608;
			return v;
		endfunction

		function longint int_sqrt(longint v);
			longint r, b;
			r = 0;
			b = 64'sd1 <<< 62;
			while (b > v)
				b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_SIZE:   brush_size = val[12:0];
				REG_SMOOTH: smoothing  = val[8:0];
				REG_RATIO:  ratio      = val[9:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic [1:0] cmd, logic signed [23:0] px,
				logic signed [23:0] py, logic [15:0] rad, logic [8:0] alpha);
			longint s, ox, oy, dx, dy, len, t, spacing;
			int n;
			stamp_t st;
			if (cmd == CMD_PRESS) begin
				if (in_stroke)
					return;
				in_stroke = 1;
				head_x = px;
				head_y = py;
				carry = 0;
				st = '{x: px, y: py, radius: rad, alpha: alpha, last: 1'b1};
				pending.push_back(st);
				return;
			end
			if (cmd == CMD_RELEASE) begin
				in_stroke = 0;
				return;
			end
			if (cmd != CMD_MOVE || !in_stroke)
				return;
			s = (smoothing > 256) ? 256 : smoothing;
			ox = head_x;
			oy = head_y;
			head_x = ox + floor256((longint'(px) - ox) * s + 128);
			head_y = oy + floor256((longint'(py) - oy) * s + 128);
			spacing = longint'(brush_size) * longint'(ratio);
			if (spacing < 256)
				spacing = 256;
			dx = head_x - ox;
			dy = head_y - oy;
			len = int_sqrt(dx * dx + dy * dy);
			n = 0;
			if (len > 0) begin
				t = spacing - carry;
				while (t <= len && n < MaxStamps) begin
					st.x = 24'(sat(ox + round_div(dx * t, len)));
					st.y = 24'(sat(oy + round_div(dy * t, len)));
					st.radius = rad;
					st.alpha = alpha;
					st.last = 1'b0;
					pending.push_back(st);
					n++;
					t += spacing;
				end
				carry = ((carry + len) % spacing) & 64'h7FFFFF;
			end
			if (n > 0)
				pending[$].last = 1'b1;
		endfunction

		function void check_stamp(stamp_t got);
			stamp_t want;
			if (pending.size() == 0) begin
				$error("unexpected stamp x=%0d y=%0d", got.x, got.y);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) begin
				$error("stamp_x expected %0d actual %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("stamp_y expected %0d actual %0d", want.y, got.y);
				errors++;
			end
			if (got.radius !== want.radius) begin
				$error("out_radius expected %0d actual %0d", want.radius, got.radius);
				errors++;
			end
			if (got.alpha !== want.alpha) begin
				$error("out_alpha expected %0d actual %0d", want.alpha, got.alpha);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_stamp expected %0d actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             s_tvalid = 0;
	logic             s_tready;
	logic [DataW-1:0] s_tdata = '0;  // pen_x, pen_y, stamp_radius, stamp_alpha, zero pad
	logic [1:0]       s_tuser = '0;  // cmd
	logic             m_tvalid;
	logic             m_tready = 0;
	logic [DataW-1:0] m_tdata;       // stamp_x, stamp_y, out_radius, out_alpha, zero pad
	logic             m_tlast;
	logic             psel = 0;
	logic             penable = 0;
	logic             pwrite = 0;
	logic [3:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	stamp_scoreboard sb;
	longint cycles = 0;
	bit     stall_long = 0;

	always #1 clk = ~clk;

	brush_stroke_stamp_spacer #(.MAX_STAMPS_PER_EVENT(MaxStamps)) dut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int wait_n;
		stamp_t got;
		@(posedge arst_n);
		forever begin
			wait_n = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0)
				wait_n = 0;
			if (stall_long) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				stall_long = 0;
			end
			if (wait_n > 0) begin
				m_tready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got.x = m_tdata[23:0];
			got.y = m_tdata[47:24];
			got.radius = m_tdata[63:48];
			got.alpha = m_tdata[72:64];
			got.last = m_tlast;
			sb.check_stamp(got);
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic send_event(logic [1:0] cmd, logic signed [23:0] px, logic signed [23:0] py,
			logic [15:0] rad, logic [8:0] alpha, bit gaps);
		int wait_n;
		wait_n = gaps ? $urandom_range(0, 11) : 0;
		if (gaps && $urandom_range(0, 3) == 0)
			wait_n = 0;
		if (wait_n > 0) begin
			s_tvalid <= 0;
			repeat (wait_n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= cmd;
		s_tdata  <= {7'b0, alpha, rad, py, px};
		do @(posedge clk); while (!s_tready);
		sb.note_request(cmd, px, py, rad, alpha);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		// a move with no stamps may still be busy
		repeat (200) @(posedge clk);
	endtask

	function automatic logic signed [23:0] near(longint base, int span);
		longint v;
		v = base + $signed($urandom_range(0, 2 * span)) - span;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return 24'(v);
	endfunction

	task automatic random_stroke(int moves, int span);
		logic signed [23:0] x, y;
		x = 24'($urandom);
		y = 24'($urandom);
		send_event(CMD_PRESS, x, y, 16'($urandom), 9'($urandom_range(0, 511)), 1);
		repeat (moves) begin
			x = near(x, span);
			y = near(y, span);
			send_event(CMD_MOVE, x, y, 16'($urandom), 9'($urandom_range(0, 511)), 1);
		end
		send_event(CMD_RELEASE, 24'($urandom), 24'($urandom), 16'($urandom), 9'($urandom), 1);
	endtask

	initial begin
		int phase;
		sb = new();
		sb.init();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: ignored events, extremes, pass-through, unused command
		send_event(CMD_MOVE, 24'sd1000, 24'sd1000, 16'd1, 9'd1, 0);
		send_event(CMD_RELEASE, 24'sd0, 24'sd0, 16'd0, 9'd0, 0);
		send_event(CMD_UNUSED, 24'sd5, 24'sd5, 16'd5, 9'd5, 0);
		send_event(CMD_PRESS, -24'sd8388608, 24'sd8388607, 16'hFFFF, 9'h1FF, 0);
		send_event(CMD_PRESS, 24'sd0, 24'sd0, 16'd0, 9'd0, 0);
		send_event(CMD_MOVE, 24'sd8388607, -24'sd8388608, 16'h0, 9'd256, 0);
		send_event(CMD_MOVE, 24'sd8388607, -24'sd8388608, 16'h1234, 9'd100, 0);
		send_event(CMD_MOVE, -24'sd1000, 24'sd2000, 16'h8000, 9'd300, 0);
		send_event(CMD_UNUSED, 24'sd5, 24'sd5, 16'd5, 9'd5, 0);
		send_event(CMD_RELEASE, 24'sd0, 24'sd0, 16'd0, 9'd0, 0);
		send_event(CMD_PRESS, 24'sd100, 24'sd100, 16'd7, 9'd9, 0);
		send_event(CMD_MOVE, 24'sd20200, 24'sd100, 16'd7, 9'd9, 0);
		drain();
		// shrink spacing mid-stroke: carry exceeds new spacing
		apb_write(REG_SIZE, 32'd1);
		apb_write(REG_RATIO, 32'd0);
		send_event(CMD_MOVE, 24'sd20500, 24'sd100, 16'd7, 9'd9, 0);
		send_event(CMD_RELEASE, 24'sd0, 24'sd0, 16'd0, 9'd0, 0);
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					apb_write(REG_SIZE, 32'd4096);
					apb_write(REG_SMOOTH, 32'd0);
					apb_write(REG_RATIO, 32'd1023);
				end
				1: begin
					apb_write(REG_SIZE, 32'd20);
					apb_write(REG_SMOOTH, 32'd511);
					apb_write(REG_RATIO, 32'd26);
				end
				2: begin
					apb_write(REG_SIZE, $urandom_range(1, 64));
					apb_write(REG_SMOOTH, $urandom_range(0, 256));
					apb_write(REG_RATIO, $urandom_range(0, 1023));
				end
				3: begin
					apb_write(REG_SIZE, 32'h1FFF);
					apb_write(REG_SMOOTH, 32'd128);
					apb_write(REG_RATIO, 32'd256);
				end
				default: begin
					apb_write(REG_SIZE, $urandom_range(1, 4096));
					apb_write(REG_SMOOTH, $urandom_range(0, 511));
					apb_write(REG_RATIO, $urandom_range(0, 1023));
				end
			endcase
			if (phase == 1)
				stall_long = 1;
			repeat (2) random_stroke($urandom_range(2, 5), (phase == 3) ? 8000000 : 6000);
			// noise: stray presses, moves, releases and unused commands
			repeat (3)
				send_event(2'($urandom_range(0, 3)), 24'($urandom), 24'($urandom),
					16'($urandom), 9'($urandom), 1);
			send_event(CMD_RELEASE, 24'sd0, 24'sd0, 16'd0, 9'd0, 1);
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
